// File: src/fls_pkg.sv
// fls_pkg: shared types, sizes and helpers for the frame latch selector.
// Used by every module of the block except the generic RAM.
package fls_pkg;

    // Frame queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Field widths
    localparam int NS_W     = 63;
    localparam int DISP_W   = 62;
    localparam int PER_W    = 32;
    localparam int HANDLE_W = 8;
    localparam int PTS_W    = 54;
    localparam int SKIP_W   = 8;
    localparam int TOTAL_W  = 32;

    // ns -> us: drop the factor of 8 by a shift, then divide by 125 with a
    // reciprocal multiply built from four 32x32 partial products.
    // ceil(2^67 / 125) is exact for every 60-bit dividend.
    localparam int NS_PER_US   = 1000;
    localparam int PRE_SHIFT   = 3;
    localparam int DIVIDEND_W  = NS_W - PRE_SHIFT;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RECIP_W     = 61;
    localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(64'h10624DD2F1A9FBE8);
    localparam int RECIP_SHIFT = 67;
    localparam int ACC_W       = DIVIDEND_W + RECIP_W;
    localparam int MUL_STEPS   = 4;
    localparam int STEP_W      = $clog2(MUL_STEPS + 2);

    // Request codes
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_VSYNC  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [HANDLE_W-1:0] frame_handle;
        logic [NS_W-1:0]     frame_time_ns;
        logic [NS_W-1:0]     target_ns;
        logic [DISP_W-1:0]   display_time_ns;
        logic [PER_W-1:0]    display_period_ns;
    } t_req;

    typedef struct packed {
        logic                latched;
        logic                dropped;
        logic [HANDLE_W-1:0] out_handle;
        logic [PTS_W-1:0]    pts_us;
        logic [NS_W-1:0]     out_target_ns;
        logic [SKIP_W-1:0]   skipped;
        logic [TOTAL_W-1:0]  total_skipped;
    } t_result;

    // One queued frame
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PTS_W-1:0]    pts;
        logic [NS_W-1:0]     target;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Classified command: cmp_ns is the target on arrival, the due limit on vsync
    typedef struct packed {
        logic                is_vsync;
        logic [HANDLE_W-1:0] handle;
        logic [PTS_W-1:0]    pts;
        logic [NS_W-1:0]     cmp_ns;
        logic                period_zero;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ARR_WR,
        B_SCAN_RD,
        B_SCAN_CHK,
        B_VS_DONE
    } t_back_state;

    // Circular index: base + off, wrapped once at the queue depth
    function automatic logic [QIDX_W-1:0] wrap_idx(input logic [QIDX_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[QIDX_W-1:0];
    endfunction

endpackage

// File: src/frame_latch_selector_core.sv
// Flow: a frame arrival is accepted, converted to microseconds by the multi-step multiply (F_DIV),
// queued and then appended in the back; a vsync result follows a scan that reads and checks each
// queued frame in turn (B_SCAN_RD, B_SCAN_CHK), plus any wait behind earlier commands.
// Busy stays high while an arrival is converted and until its command is pushed, and while a
// vsync command is pushed; two commands may wait between front and back. The receiver cannot stall;
// results are strobed for one cycle. Reset (synchronous, active low) empties queues and counters.
module frame_latch_selector_core
    import fls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Front: accept, classify, convert timestamp
    fls_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_push (push),
        .o_cmd  (push_cmd),
        .i_full (full)
    );

    // Command queue
    fls_cmd_fifo u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_cmd  (pop_cmd),
        .o_empty(empty)
    );

    // Back: frame queue and latch selection
    fls_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_result(o_result)
    );

endmodule

// File: src/fls_ram.sv
// fls_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module fls_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 4,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fls_cmd_fifo.sv
// fls_cmd_fifo: short command queue between the front and back of the selector.
// Depends on fls_pkg.
module fls_cmd_fifo
    import fls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                  r_slot [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wptr;
    logic [CMDQ_PTR_W-1:0] r_rptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rptr];

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count (depth is a power of two, pointers wrap naturally)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/fls_front.sv
// fls_front: accepts transactions, converts frame timestamps to microseconds
// with a multi-cycle reciprocal multiply, computes the vsync due limit. Depends on fls_pkg.
module fls_front
    import fls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_full
);

    t_front_state      r_state, n_state;
    t_req              r_req, n_req;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [1:0]        r_prod_sh, n_prod_sh;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [STEP_W-1:0] r_step, n_step;
    logic              accept;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [ACC_W-1:0]  addend;
    logic [NS_W-1:0]   limit;
    logic              is_vsync;

    assign accept = start && !busy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_state = (i_req.req_type == REQ_VSYNC) ? F_PUSH : F_DIV;
                end
            end
            F_DIV: begin
                if (r_step == STEP_W'(MUL_STEPS)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy   = (r_state != F_IDLE);
        o_push = (r_state == F_PUSH);
    end

    // Partial product operands: step bit 1 picks the dividend half, bit 0 the
    // reciprocal half; the registered product lands 0, 32 or 64 bits up
    always_comb begin
        mul_a  = r_step[1] ? MUL_W'(r_req.frame_time_ns[NS_W-1:PRE_SHIFT+MUL_W])
                           : r_req.frame_time_ns[PRE_SHIFT +: MUL_W];
        mul_b  = r_step[0] ? MUL_W'(RECIP_125[RECIP_W-1:MUL_W]) : RECIP_125[MUL_W-1:0];
        addend = ACC_W'(r_prod) << {r_prod_sh, 5'b0};
    end

    // Datapath next values: one product per step, accumulated a step later
    always_comb begin
        n_req     = r_req;
        n_prod    = r_prod;
        n_prod_sh = r_prod_sh;
        n_acc     = r_acc;
        n_step    = r_step;
        if (accept) begin
            n_req  = i_req;
            n_acc  = '0;
            n_step = '0;
        end else if (r_state == F_DIV) begin
            n_prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
            n_prod_sh = {1'b0, r_step[1]} + {1'b0, r_step[0]};
            if (r_step != '0) begin
                n_acc = r_acc + addend;
            end
            n_step = r_step + 1'b1;
        end
    end

    // Command build: due limit is display time plus half a period
    always_comb begin
        is_vsync           = (r_req.req_type == REQ_VSYNC);
        limit              = NS_W'(r_req.display_time_ns) + NS_W'(r_req.display_period_ns >> 1);
        o_cmd.is_vsync     = is_vsync;
        o_cmd.handle       = r_req.frame_handle;
        o_cmd.pts          = r_acc[RECIP_SHIFT +: PTS_W];
        o_cmd.cmp_ns       = is_vsync ? limit : r_req.target_ns;
        o_cmd.period_zero  = (r_req.display_period_ns == '0);
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_prod    <= n_prod;
        r_prod_sh <= n_prod_sh;
        r_acc     <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: src/fls_back.sv
// fls_back: frame queue and vsync selection; executes commands in order and
// drives the result strobe. Depends on fls_pkg and fls_ram.
module fls_back
    import fls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result
);

    t_back_state        r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [QIDX_W-1:0]  r_head, n_head;
    logic [QIDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SKIP_W-1:0]  r_pending, n_pending;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_found, n_found;
    logic [CNT_W-1:0]   r_due_idx, n_due_idx;
    t_entry             r_hit, n_hit;
    logic               r_valid, n_valid;
    t_result            r_result, n_result;

    logic               we;
    logic [QIDX_W-1:0]  raddr;
    t_entry             wentry;
    t_entry             rentry;
    logic [ENTRY_W-1:0] rdata;
    logic               full;
    logic               due;
    logic [SKIP_W:0]    skip_sum;
    logic [SKIP_W-1:0]  skip_sat;
    logic [CNT_W-1:0]   consumed;

    fls_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_tail),
        .i_wdata(wentry),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rentry = t_entry'(rdata);
    assign full   = (r_count == CNT_W'(QUEUE_DEPTH));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    if (!i_cmd.is_vsync) begin
                        n_state = B_ARR_WR;
                    end else if (r_count != '0) begin
                        n_state = B_SCAN_RD;
                    end else begin
                        n_state = B_VS_DONE;
                    end
                end
            end
            B_ARR_WR:  n_state = B_IDLE;
            B_SCAN_RD: n_state = B_SCAN_CHK;
            B_SCAN_CHK: begin
                n_state = (r_idx + 1'b1 == r_count) ? B_VS_DONE : B_SCAN_RD;
            end
            B_VS_DONE: n_state = B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        n_cmd     = r_cmd;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_pending = r_pending;
        n_total   = r_total;
        n_idx     = r_idx;
        n_found   = r_found;
        n_due_idx = r_due_idx;
        n_hit     = r_hit;
        n_valid   = 1'b0;
        n_result  = r_result;
        o_pop     = 1'b0;
        we        = 1'b0;
        raddr     = r_head;
        wentry    = '{handle: r_cmd.handle, pts: r_cmd.pts, target: r_cmd.cmp_ns};
        due       = 1'b0;
        skip_sum  = '0;
        skip_sat  = '0;
        consumed  = '0;

        unique case (r_state)
            // Take the next command; head is being read for a possible eviction
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end

            // Arrival: evict the oldest when full, then append
            B_ARR_WR: begin
                we     = 1'b1;
                n_tail = wrap_idx(r_tail, CNT_W'(1));
                n_result.latched       = 1'b0;
                n_result.dropped       = full;
                n_result.out_handle    = '0;
                n_result.pts_us        = '0;
                n_result.out_target_ns = '0;
                if (full) begin
                    n_head    = wrap_idx(r_head, CNT_W'(1));
                    n_pending = (r_pending == '1) ? r_pending : r_pending + 1'b1;
                    n_total   = r_total + 1'b1;
                    n_result.out_handle = rentry.handle;
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_result.skipped       = n_pending;
                n_result.total_skipped = n_total;
                n_valid                = 1'b1;
            end

            B_SCAN_RD: begin
                raddr = wrap_idx(r_head, r_idx);
            end

            // Due test on one entry; remember the newest due one
            B_SCAN_CHK: begin
                if (rentry.target == '0 || r_cmd.period_zero) begin
                    due = (r_idx == '0);
                end else begin
                    due = (rentry.target <= r_cmd.cmp_ns);
                end
                if (due) begin
                    n_found   = 1'b1;
                    n_due_idx = r_idx;
                    n_hit     = rentry;
                end
                n_idx = r_idx + 1'b1;
            end

            // Latch the selected due frame, if any, and drop everything older
            B_VS_DONE: begin
                skip_sum = (SKIP_W + 1)'(r_pending) + (SKIP_W + 1)'(r_due_idx);
                skip_sat = skip_sum[SKIP_W] ? '1 : skip_sum[SKIP_W-1:0];
                consumed = r_due_idx + 1'b1;
                n_result.dropped = 1'b0;
                if (r_found) begin
                    n_head    = wrap_idx(r_head, consumed);
                    n_count   = r_count - consumed;
                    n_total   = r_total + TOTAL_W'(r_due_idx);
                    n_pending = '0;
                    n_result.latched       = 1'b1;
                    n_result.out_handle    = r_hit.handle;
                    n_result.pts_us        = r_hit.pts;
                    n_result.out_target_ns = r_hit.target;
                    n_result.skipped       = skip_sat;
                    n_result.total_skipped = n_total;
                end else begin
                    n_result.latched       = 1'b0;
                    n_result.out_handle    = '0;
                    n_result.pts_us        = '0;
                    n_result.out_target_ns = '0;
                    n_result.skipped       = r_pending;
                    n_result.total_skipped = r_total;
                end
                n_valid = 1'b1;
            end

            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_due_idx <= n_due_idx;
        r_hit     <= n_hit;
        r_result  <= n_result;
    end

    // Control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_pending <= '0;
            r_total   <= '0;
            r_found   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_pending <= n_pending;
            r_total   <= n_total;
            r_found   <= n_found;
            r_valid   <= n_valid;
        end
    end

endmodule
